// File: src/assert_macros.svh
// Assertion macros shared by the servo pulse and slew estimator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define SPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sps assertion failed");

// Next-cycle implication under synchronous reset.
`define SPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sps assertion failed");

`endif

// File: src/sps_pkg.sv
// Types and constants for the servo pulse and slew estimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sps_pkg;

  localparam int ANGLE_W   = 16;
  localparam int PULSE_W   = 16;
  localparam int SLEW_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  // divider geometry: 16 x 16 bit pulse product over a 16 bit angle span
  localparam int DIV_W     = 32;
  localparam int DVS_W     = 16;
  localparam int DIV_CNT_W = 5;

  // slew step: 20 x 17 bit product over one million, taken as a shift by six and a
  // multiply by the rounded-up reciprocal of 15625, exact for a 31-bit operand
  localparam int SLEW_PROD_W  = 37;
  localparam int MPS_SHIFT    = 6;
  localparam int SLEW_Y_W     = SLEW_PROD_W - MPS_SHIFT;
  localparam int RECIP_W      = 32;
  localparam int RECIP_PROD_W = SLEW_Y_W + RECIP_W;
  localparam int RECIP_SHIFT  = 45;
  localparam int STEP_W       = 18;

  localparam int                 MICROS_PER_SECOND = 1000000;
  localparam logic [RECIP_W-1:0] RECIP_15625       = 32'd2251799814;
  localparam logic [PULSE_W-1:0] REST_RESET        = 16'd5000;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REST      = 3'd6;

  typedef struct packed {
    logic [PULSE_W-1:0]        min_pulse_us;
    logic [PULSE_W-1:0]        max_pulse_us;
    logic signed [ANGLE_W-1:0] min_angle;
    logic signed [ANGLE_W-1:0] max_angle;
    logic [SLEW_W-1:0]         slew_rate;
    logic                      channel_enable;
    logic [PULSE_W-1:0]        rest_interval_us;
  } sps_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_MAP,
    ST_SLEW,
    ST_SLEW_MUL,
    ST_SLEW_STEP,
    ST_WRITE
  } sps_state_t;

endpackage

`default_nettype wire

// File: src/sps_cfg_regs.sv
// Configuration register file of the servo pulse and slew estimator.
// Depends on sps_pkg for register indexes and the configuration struct.
`default_nettype none

module sps_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sps_pkg::CFG_DAT_W-1:0]  cfg_data,
  output sps_pkg::sps_cfg_t                   cfg
);
  import sps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse_us     <= '0;
      cfg.max_pulse_us     <= '0;
      cfg.min_angle        <= '0;
      cfg.max_angle        <= '0;
      cfg.slew_rate        <= '0;
      cfg.channel_enable   <= 1'b0;
      cfg.rest_interval_us <= REST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PULSE: cfg.min_pulse_us     <= cfg_data[PULSE_W-1:0];
        REG_MAX_PULSE: cfg.max_pulse_us     <= cfg_data[PULSE_W-1:0];
        REG_MIN_ANGLE: cfg.min_angle        <= cfg_data[ANGLE_W-1:0];
        REG_MAX_ANGLE: cfg.max_angle        <= cfg_data[ANGLE_W-1:0];
        REG_SLEW_RATE: cfg.slew_rate        <= cfg_data[SLEW_W-1:0];
        REG_ENABLE:    cfg.channel_enable   <= cfg_data[0];
        REG_REST:      cfg.rest_interval_us <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/sps_divider.sv
// Restoring divider for the pulse mapping, one quotient bit per cycle.
// Depends on sps_pkg for its widths and on assert_macros.svh.
`default_nettype none

module sps_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sps_pkg::DIV_W-1:0]  dividend,
  input  wire logic [sps_pkg::DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [sps_pkg::DIV_W-1:0]       quotient
);
  import sps_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_W-1:0]     quo;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem, quo[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

  `include "assert_macros.svh"

  `SPS_ASSERT_IMP(a_rem_below_divisor, clk, rst, busy && dvs != '0, rem < dvs)
  `SPS_ASSERT_NXT(a_start_runs, clk, rst, start, busy && cnt == '0)
  `SPS_ASSERT_IMP(a_done_after_run, clk, rst, done, !busy && $past(busy))

endmodule

`default_nettype wire

// File: src/servo_pulse_and_slew_estimator_core.sv
// Servo pulse and slew estimator: clamps a target angle, maps it onto the pulse range and
// advances a shaft angle estimate. Uses sps_pkg, sps_cfg_regs, sps_divider, assert_macros.svh.
//
// An accepted item passes through a load state, the 32-step pass of the pulse mapping
// through the restoring divider, the slew states ST_SLEW, ST_SLEW_MUL and ST_SLEW_STEP,
// which divide by one million as a shift and a reciprocal multiplication, and a write
// state. A zero angle span or inverted limits skip the divider pass and a zero slew rate
// skips the slew multiply. in_ready is high only while the sequencer is idle; a result
// waits in the output register until taken, and the next item can be accepted in the
// cycle after the result is written there.
// An item arriving while the channel is disabled is taken and dropped without a result.
// Configuration writes are taken every cycle and must only be made while the block is idle.
`default_nettype none

module servo_pulse_and_slew_estimator_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sps_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [sps_pkg::ANGLE_W-1:0]  target_angle,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [sps_pkg::PULSE_W-1:0]              pulse_width_us,
  output logic signed [sps_pkg::ANGLE_W-1:0]       estimated_angle
);
  import sps_pkg::*;

  sps_cfg_t   cfg;
  sps_state_t state;
  sps_state_t state_next;

  logic signed [ANGLE_W-1:0] target;
  logic signed [ANGLE_W-1:0] angle_estimate;
  logic [PULSE_W-1:0]        pulse;
  logic                      dp_neg;

  logic signed [ANGLE_W-1:0] lo_clamp;
  logic signed [ANGLE_W-1:0] clamped;
  logic signed [ANGLE_W:0]   span;
  logic signed [ANGLE_W:0]   diff;
  logic signed [PULSE_W:0]   dp;
  logic [PULSE_W-1:0]        dp_mag;
  logic [2*PULSE_W-1:0]      map_prod;
  logic [PULSE_W:0]          spent;
  logic [SLEW_PROD_W-1:0]    slew_prod;
  logic [SLEW_Y_W-1:0]       slew_y;
  logic [RECIP_PROD_W-1:0]   recip_prod;
  logic [STEP_W-1:0]         step;

  logic signed [SLEW_W-1:0]  est_ext;
  logic signed [SLEW_W-1:0]  tgt_ext;
  logic signed [SLEW_W-1:0]  step_ext;
  logic signed [SLEW_W-1:0]  est_down;
  logic signed [SLEW_W-1:0]  est_up;
  logic signed [ANGLE_W-1:0] est_slew;

  logic                      div_start;
  logic                      div_done;
  logic [DIV_W-1:0]          div_dividend;
  logic [DVS_W-1:0]          div_divisor;
  logic [DIV_W-1:0]          div_quo;
  logic                      span_pos;
  logic                      out_free;

  sps_cfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    lo_clamp   = (target < cfg.min_angle) ? cfg.min_angle : target;
    clamped    = (lo_clamp > cfg.max_angle) ? cfg.max_angle : lo_clamp;
    span       = {cfg.max_angle[ANGLE_W-1], cfg.max_angle}
               - {cfg.min_angle[ANGLE_W-1], cfg.min_angle};
    diff       = {clamped[ANGLE_W-1], clamped} - {cfg.min_angle[ANGLE_W-1], cfg.min_angle};
    dp         = {1'b0, cfg.max_pulse_us} - {1'b0, cfg.min_pulse_us};
    dp_mag     = dp[PULSE_W] ? PULSE_W'(-dp) : dp[PULSE_W-1:0];
    map_prod   = (2*PULSE_W)'(dp_mag) * (2*PULSE_W)'(diff[ANGLE_W-1:0]);
    span_pos   = !span[ANGLE_W] && (span != '0);
    spent      = {1'b0, cfg.rest_interval_us} + {1'b0, pulse};
    slew_prod  = SLEW_PROD_W'(cfg.slew_rate) * SLEW_PROD_W'(spent);
    recip_prod = RECIP_PROD_W'(slew_y) * RECIP_PROD_W'(RECIP_15625);
    out_free   = !out_valid || out_ready;
  end

  always_comb begin
    est_ext  = SLEW_W'(angle_estimate);
    tgt_ext  = SLEW_W'(target);
    step_ext = {2'b00, step};
    est_down = est_ext - step_ext;
    est_up   = est_ext + step_ext;
    if (angle_estimate > target) begin
      est_slew = (est_down < tgt_ext) ? target : est_down[ANGLE_W-1:0];
    end else if (angle_estimate < target) begin
      est_slew = (est_up > tgt_ext) ? target : est_up[ANGLE_W-1:0];
    end else begin
      est_slew = angle_estimate;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && cfg.channel_enable) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = span_pos ? ST_DIV_MAP : ST_SLEW;
      end
      ST_DIV_MAP: begin
        if (div_done) begin
          state_next = ST_SLEW;
        end
      end
      ST_SLEW: begin
        state_next = (cfg.slew_rate == '0) ? ST_WRITE : ST_SLEW_MUL;
      end
      ST_SLEW_MUL: begin
        state_next = ST_SLEW_STEP;
      end
      ST_SLEW_STEP: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(map_prod);
    div_divisor  = DVS_W'(span[ANGLE_W-1:0]);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOAD: begin
        div_start = span_pos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      angle_estimate <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_WRITE && out_free) begin
        out_valid <= 1'b1;
      end
      if (state == ST_SLEW && cfg.slew_rate == '0) begin
        angle_estimate <= target;
      end
      if (state == ST_SLEW_STEP) begin
        angle_estimate <= est_slew;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          target <= target_angle;
        end
      end
      ST_LOAD: begin
        dp_neg <= dp[PULSE_W];
        if (span == '0) begin
          pulse <= cfg.min_pulse_us;
        end else if (span[ANGLE_W]) begin
          pulse <= cfg.max_pulse_us;
        end
      end
      ST_DIV_MAP: begin
        if (div_done) begin
          pulse <= dp_neg ? cfg.min_pulse_us - div_quo[PULSE_W-1:0]
                          : cfg.min_pulse_us + div_quo[PULSE_W-1:0];
        end
      end
      ST_SLEW: begin
        slew_y <= slew_prod[SLEW_PROD_W-1:MPS_SHIFT];
      end
      ST_SLEW_MUL: begin
        step <= recip_prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
      end
      ST_WRITE: begin
        if (out_free) begin
          pulse_width_us  <= pulse;
          estimated_angle <= angle_estimate;
        end
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"

  `SPS_ASSERT_IMP(a_done_in_div, clk, rst, div_done, state == ST_DIV_MAP)
  `SPS_ASSERT_NXT(a_disabled_drops, clk, rst,
                  in_valid && in_ready && !cfg.channel_enable,
                  state == ST_IDLE && !$rose(out_valid))
  `SPS_ASSERT_IMP(a_result_matches_state, clk, rst, $rose(out_valid),
                  estimated_angle == angle_estimate)

endmodule

`default_nettype wire

// File: tb/servo_pulse_and_slew_estimator_core_tb.sv
// Self-checking testbench for servo_pulse_and_slew_estimator_core: predicts the pulse width
// and the shaft angle estimate for every target accepted while the channel is enabled and
// checks each result item in order. Depends on sps_pkg and the core RTL only.
module servo_pulse_and_slew_estimator_core_tb;
  import sps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int ITEM_GOAL    = 1150;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [PULSE_W-1:0]        pulse;
    logic signed [ANGLE_W-1:0] angle;
  } servo_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DAT_W-1:0]      cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] target_angle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PULSE_W-1:0]        pulse_width_us;
  logic signed [ANGLE_W-1:0] estimated_angle;

  logic [PULSE_W-1:0]        min_pulse = '0;
  logic [PULSE_W-1:0]        max_pulse = '0;
  logic [PULSE_W-1:0]        rest_us = REST_RESET;
  logic signed [ANGLE_W-1:0] min_ang = '0;
  logic signed [ANGLE_W-1:0] max_ang = '0;
  logic signed [ANGLE_W-1:0] shaft_est = '0;
  logic [SLEW_W-1:0]         slew = '0;
  logic                      chan_en = 1'b0;

  logic signed [ANGLE_W-1:0] target_q[$];
  servo_result_t             expected_q[$];
  int                        errors = 0;
  int unsigned               in_wait = 0;
  int unsigned               out_wait = 0;
  int unsigned               hold_left = 0;
  int unsigned               results_seen = 0;
  bit                        in_idle_on = 1'b1;
  bit                        out_idle_on = 1'b1;

  servo_pulse_and_slew_estimator_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target_angle(target_angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pulse_width_us(pulse_width_us),
    .estimated_angle(estimated_angle)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  task automatic predict_servo(input logic signed [ANGLE_W-1:0] tgt);
    longint        t, lo, hi, clamped, span, pulse, stepv, est;
    servo_result_t r;
    if (!chan_en) return;
    t = longint'(tgt);
    lo = longint'(min_ang);
    hi = longint'(max_ang);
    clamped = (t < lo) ? lo : t;
    if (clamped > hi) clamped = hi;
    span = hi - lo;
    if (span == 0) begin
      pulse = longint'(min_pulse);
    end else begin
      pulse = longint'(min_pulse)
            + (longint'(max_pulse) - longint'(min_pulse)) * (clamped - lo) / span;
    end
    est = longint'(shaft_est);
    if (slew == '0) begin
      est = t;
    end else begin
      stepv = (longint'(slew) * (longint'(rest_us) + pulse)) / longint'(MICROS_PER_SECOND);
      if (est > t) begin
        est = est - stepv;
        if (est < t) est = t;
      end else if (est < t) begin
        est = est + stepv;
        if (est > t) est = t;
      end
    end
    shaft_est = est[ANGLE_W-1:0];
    r.pulse = pulse[PULSE_W-1:0];
    r.angle = shaft_est;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin : drive_targets
    int unsigned gap;
    if (rst) begin
      in_valid <= 1'b0;
      in_wait <= 0;
    end else if (!in_valid || in_ready) begin
      gap = in_wait;
      if (in_valid) begin
        predict_servo(target_angle);
        if ($urandom_range(0, 40) == 0) in_idle_on = !in_idle_on;
        gap = in_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (gap == 0 && target_q.size() != 0) begin
        target_angle <= target_q.pop_front();
        in_valid <= 1'b1;
        in_wait <= 0;
      end else begin
        in_valid <= 1'b0;
        in_wait <= (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    servo_result_t want;
    int unsigned   stall;
    int unsigned   hold;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait <= 0;
      hold_left <= 0;
    end else begin
      stall = out_wait;
      hold = hold_left;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: pulse_width_us %0d estimated_angle %0d",
                   $time, pulse_width_us, estimated_angle);
        end else begin
          want = expected_q.pop_front();
          if (pulse_width_us !== want.pulse) begin
            errors++;
            $display("%0t: pulse_width_us expected %0d actual %0d",
                     $time, want.pulse, pulse_width_us);
          end
          if (estimated_angle !== want.angle) begin
            errors++;
            $display("%0t: estimated_angle expected %0d actual %0d",
                     $time, want.angle, estimated_angle);
          end
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 700) hold = HOLD_CYCLES;
        if ($urandom_range(0, 40) == 0) out_idle_on = !out_idle_on;
        stall = out_idle_on ? $urandom_range(0, 4) : 0;
      end else if (out_valid && stall != 0) begin
        stall = stall - 1;
      end
      if (hold != 0) hold = hold - 1;
      out_ready <= (hold == 0 && stall == 0);
      out_wait <= stall;
      hold_left <= hold;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_PULSE: min_pulse = value[PULSE_W-1:0];
      REG_MAX_PULSE: max_pulse = value[PULSE_W-1:0];
      REG_MIN_ANGLE: min_ang = value[ANGLE_W-1:0];
      REG_MAX_ANGLE: max_ang = value[ANGLE_W-1:0];
      REG_SLEW_RATE: slew = value[SLEW_W-1:0];
      REG_ENABLE:    chan_en = value[0];
      REG_REST:      rest_us = value[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DAT_W-1:0] pad16(input int v);
    logic [CFG_DAT_W-17:0] junk;
    logic [15:0]           low;
    junk = (CFG_DAT_W-16)'($urandom);
    low = v[15:0];
    return {junk, low};
  endfunction

  task automatic setup(input int minp, maxp, mina, maxa, slw, en, rest);
    logic [CFG_DAT_W-2:0] junk;
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_MIN_PULSE, pad16(minp));
    write_reg(REG_MAX_PULSE, pad16(maxp));
    write_reg(REG_MIN_ANGLE, pad16(mina));
    write_reg(REG_NONE, CFG_DAT_W'($urandom));
    write_reg(REG_MAX_ANGLE, pad16(maxa));
    write_reg(REG_SLEW_RATE, CFG_DAT_W'(slw));
    write_reg(REG_ENABLE, {junk, en[0]});
    write_reg(REG_REST, pad16(rest));
    cfg_valid <= 1'b0;
  endtask

  task automatic offer(input int a);
    target_q.push_back(a[ANGLE_W-1:0]);
  endtask

  // drain, then let any dropped item clear the sequencer
  task automatic settle();
    while (target_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_pulse();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 65535 : 0;
      1: return $urandom_range(0, 65535);
      default: return $urandom_range(500, 2500);
    endcase
  endfunction

  initial begin : run_test
    int placed, n, k, t, rep, a, b;
    int minp, maxp, mina, maxa, slw, en, rest;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(18000);
    offer(-18000);
    settle();

    setup(1000, 2000, -9000, 9000, 0, 1, 20000);
    offer(-18000);
    offer(18000);
    offer(0);
    offer(-9000);
    offer(9000);
    offer(1);
    settle();

    setup(65535, 0, -18000, 18000, 9000, 1, 65535);
    offer(18000);
    offer(18000);
    offer(-18000);
    offer(5);
    offer(-5);
    settle();

    setup(0, 65535, 18000, 18000, 1, 1, 0);
    offer(18000);
    offer(-18000);
    offer(500);
    settle();

    setup(600, 2400, 18000, -18000, 0, 1, 5000);
    offer(0);
    offer(18000);
    offer(-18000);
    settle();

    setup(600, 2400, -18000, 18000, 1000000, 0, 5000);
    offer(7);
    offer(-7);
    settle();

    placed = 0;
    while (placed < ITEM_GOAL) begin
      minp = pick_pulse();
      maxp = pick_pulse();
      a = int'($urandom_range(0, 36000)) - 18000;
      b = int'($urandom_range(0, 36000)) - 18000;
      case ($urandom_range(0, 5))
        0: begin
          mina = -18000;
          maxa = 18000;
        end
        1: begin
          mina = a;
          maxa = a;
        end
        2: begin
          mina = (a > b) ? a : b;
          maxa = (a > b) ? b : a;
        end
        default: begin
          mina = (a < b) ? a : b;
          maxa = (a < b) ? b : a;
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1: slw = 0;
        2: slw = 1000000;
        3, 4: slw = $urandom_range(1, 200);
        default: slw = $urandom_range(1, 1000000);
      endcase
      case ($urandom_range(0, 5))
        0: rest = 0;
        1: rest = 65535;
        2: rest = 5000;
        default: rest = $urandom_range(0, 65535);
      endcase
      en = int'($urandom_range(0, 7) != 0);
      setup(minp, maxp, mina, maxa, slw, en, rest);

      n = $urandom_range(10, 70);
      k = 0;
      while (k < n) begin
        case ($urandom_range(0, 7))
          0: t = 18000;
          1: t = -18000;
          2: t = int'(min_ang);
          3: t = int'(max_ang);
          default: t = int'($urandom_range(0, 36000)) - 18000;
        endcase
        rep = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 1;
        repeat (rep) begin
          offer(t);
          k++;
        end
      end
      placed += k;
      settle();
    end

    if (errors == 0) begin
      $display("PASS servo_pulse_and_slew_estimator_core");
    end else begin
      $display("FAIL servo_pulse_and_slew_estimator_core");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAIL servo_pulse_and_slew_estimator_core");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/sps_pkg.sv
src/sps_cfg_regs.sv
src/sps_divider.sv
src/servo_pulse_and_slew_estimator_core.sv
tb/servo_pulse_and_slew_estimator_core_tb.sv
